FILE: rtl/sle_pkg.sv
// Package for the sequential list engine: request codes, status codes,
// controller states and the result record.
// No dependencies.
package sle_pkg;

    typedef enum logic [3:0] {
        OP_INSERT_AT    = 4'd0,
        OP_APPEND       = 4'd1,
        OP_READ_AT      = 4'd2,
        OP_FIND         = 4'd3,
        OP_UPDATE_AT    = 4'd4,
        OP_UPDATE_MATCH = 4'd5,
        OP_REMOVE_AT    = 4'd6,
        OP_REMOVE_MATCH = 4'd7,
        OP_PRIOR        = 4'd8,
        OP_NEXT         = 4'd9,
        OP_CLEAR        = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BOUNDS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FLUSH,
        S_PUT,
        S_RD,
        S_RDW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [4:0]  element_count;
        logic [4:0]  found_position;
        logic [31:0] read_value;
        t_status     status;
    } t_result;

endpackage

FILE: rtl/sequential_list_engine.sv
// Append, update_at, clear and rejected requests go from S_IDLE straight to S_DONE;
// read_at passes through S_RD and S_RDW. Match requests scan one entry per cycle
// from the top, and insert/remove move one entry per cycle through the single store
// port pair; one request is in work at a time.
// Reset clears the entry count and control state; the entry store is not cleared.
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // position[4:0], value[36:5], new_value[68:37]
    input  logic [3:0]  i_s_tuser,  // req_type[3:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata   // status[1:0], read_value[33:2],
                                    // found_position[38:34], element_count[43:39]
);

    localparam int AW = $clog2(DEPTH);

    logic              w_res_vld;
    logic              w_res_rdy;
    t_result           w_res;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WIDTH-1:0]  w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [WIDTH-1:0]  w_rdata;

    logic              r_out_vld;
    t_result           r_out;

    sle_ctrl #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_vld (i_s_tvalid),
        .o_req_rdy (o_s_tready),
        .i_op      (t_op'(i_s_tuser)),
        .i_pos     (i_s_tdata[4:0]),
        .i_val     (WIDTH'(i_s_tdata[36:5])),
        .i_nval    (WIDTH'(i_s_tdata[68:37])),
        .o_res_vld (w_res_vld),
        .i_res_rdy (w_res_rdy),
        .o_res     (w_res),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata),
        .o_raddr   (w_raddr),
        .i_rdata   (w_rdata)
    );

    sle_mem #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_res_rdy = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_vld && w_res_rdy) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld && w_res_rdy) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0000, r_out.element_count, r_out.found_position,
                         r_out.read_value, r_out.status};

endmodule

FILE: rtl/sle_mem.sv
// Entry store of the sequential list engine: one write port, one read port
// with registered read data.
// Depends on nothing.
module sle_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sle_ctrl.sv
// Sequencer of the sequential list engine: bounds checks, match scan and
// entry shifting through the single store port pair.
// Depends on sle_pkg.
module sle_ctrl
    import sle_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_vld,
    output logic                     o_req_rdy,
    input  t_op                      i_op,
    input  logic [4:0]               i_pos,
    input  logic [WIDTH-1:0]         i_val,
    input  logic [WIDTH-1:0]         i_nval,
    output logic                     o_res_vld,
    input  logic                     i_res_rdy,
    output t_result                  o_res,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [WIDTH-1:0]         o_wdata,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  logic [WIDTH-1:0]         i_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > 5) ? CW : 5) + 1;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [WIDTH-1:0]  r_val, n_val;
    logic [WIDTH-1:0]  r_nval, n_nval;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_stop, n_stop;
    logic              r_up, n_up;
    logic              r_mv_vld, n_mv_vld;
    logic [AW-1:0]     r_mv_addr, n_mv_addr;
    logic              r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]     r_cmp_idx, n_cmp_idx;
    t_status           r_st, n_st;
    logic [WIDTH-1:0]  r_rd, n_rd;
    logic [CW-1:0]     r_fp, n_fp;

    logic [PW-1:0]     w_p;
    logic [PW-1:0]     w_c;
    logic [CW-1:0]     w_m;

    assign w_p = PW'(i_pos);
    assign w_c = PW'(r_count);
    assign w_m = CW'(r_cmp_idx) + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_mv_vld  <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_mv_vld  <= n_mv_vld;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_val     <= n_val;
        r_nval    <= n_nval;
        r_idx     <= n_idx;
        r_stop    <= n_stop;
        r_up      <= n_up;
        r_mv_addr <= n_mv_addr;
        r_cmp_idx <= n_cmp_idx;
        r_st      <= n_st;
        r_rd      <= n_rd;
        r_fp      <= n_fp;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_val     = r_val;
        n_nval    = r_nval;
        n_count   = r_count;
        n_idx     = r_idx;
        n_stop    = r_stop;
        n_up      = r_up;
        n_mv_vld  = r_mv_vld;
        n_mv_addr = r_mv_addr;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_st      = r_st;
        n_rd      = r_rd;
        n_fp      = r_fp;
        o_we      = 1'b0;
        o_waddr   = '0;
        o_wdata   = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_vld) begin
                    n_op    = i_op;
                    n_val   = i_val;
                    n_nval  = i_nval;
                    n_st    = ST_OK;
                    n_rd    = '0;
                    n_fp    = '0;
                    n_state = S_DONE;
                    unique case (i_op)
                        OP_INSERT_AT: begin
                            if (w_p == '0 || w_p > w_c + PW'(1)) begin
                                n_st = ST_BOUNDS;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_st = ST_FULL;
                            end else if (w_p == w_c + PW'(1)) begin
                                o_we    = 1'b1;
                                o_waddr = AW'(r_count);
                                o_wdata = i_val;
                                n_count = r_count + CW'(1);
                                n_fp    = CW'(w_p);
                            end else begin
                                n_idx    = AW'(r_count - CW'(1));
                                n_stop   = AW'(w_p - PW'(1));
                                n_up     = 1'b1;
                                n_mv_vld = 1'b0;
                                n_fp     = CW'(w_p);
                                n_state  = S_SHIFT;
                            end
                        end
                        OP_APPEND: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_st = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = AW'(r_count);
                                o_wdata = i_val;
                                n_count = r_count + CW'(1);
                                n_fp    = r_count + CW'(1);
                            end
                        end
                        OP_READ_AT, OP_UPDATE_AT, OP_REMOVE_AT: begin
                            if (w_p == '0 || w_p > w_c) begin
                                n_st = ST_BOUNDS;
                            end else begin
                                n_fp = CW'(w_p);
                                if (i_op == OP_READ_AT) begin
                                    n_idx   = AW'(w_p - PW'(1));
                                    n_state = S_RD;
                                end else if (i_op == OP_UPDATE_AT) begin
                                    o_we    = 1'b1;
                                    o_waddr = AW'(w_p - PW'(1));
                                    o_wdata = i_nval;
                                end else if (w_p == w_c) begin
                                    n_count = r_count - CW'(1);
                                end else begin
                                    n_idx    = AW'(w_p);
                                    n_stop   = AW'(w_c - PW'(1));
                                    n_up     = 1'b0;
                                    n_mv_vld = 1'b0;
                                    n_state  = S_SHIFT;
                                end
                            end
                        end
                        OP_FIND, OP_UPDATE_MATCH, OP_REMOVE_MATCH, OP_PRIOR, OP_NEXT: begin
                            if (r_count == '0) begin
                                n_st = ST_NOTFOUND;
                            end else begin
                                n_idx     = AW'(r_count - CW'(1));
                                n_cmp_vld = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_idx;
                if (r_idx != '0) begin
                    n_idx = r_idx - AW'(1);
                end
                if (r_cmp_vld) begin
                    if (i_rdata == r_val) begin
                        n_fp    = w_m;
                        n_state = S_DONE;
                        unique case (r_op)
                            OP_UPDATE_MATCH: begin
                                o_we    = 1'b1;
                                o_waddr = r_cmp_idx;
                                o_wdata = r_nval;
                            end
                            OP_REMOVE_MATCH: begin
                                if (w_m == r_count) begin
                                    n_count = r_count - CW'(1);
                                end else begin
                                    n_idx    = AW'(w_m);
                                    n_stop   = AW'(r_count - CW'(1));
                                    n_up     = 1'b0;
                                    n_mv_vld = 1'b0;
                                    n_state  = S_SHIFT;
                                end
                            end
                            OP_PRIOR: begin
                                if (r_cmp_idx == '0) begin
                                    n_st = ST_NOTFOUND;
                                end else begin
                                    n_idx   = r_cmp_idx - AW'(1);
                                    n_state = S_RD;
                                end
                            end
                            OP_NEXT: begin
                                if (w_m >= r_count) begin
                                    n_st = ST_NOTFOUND;
                                end else begin
                                    n_idx   = r_cmp_idx + AW'(1);
                                    n_state = S_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else if (r_cmp_idx == '0) begin
                        n_st    = ST_NOTFOUND;
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (r_mv_vld) begin
                    o_we    = 1'b1;
                    o_waddr = r_up ? r_mv_addr + AW'(1) : r_mv_addr - AW'(1);
                    o_wdata = i_rdata;
                end
                n_mv_vld  = 1'b1;
                n_mv_addr = r_idx;
                if (r_idx == r_stop) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_up ? r_idx - AW'(1) : r_idx + AW'(1);
                end
            end
            S_FLUSH: begin
                o_we     = 1'b1;
                o_waddr  = r_up ? r_mv_addr + AW'(1) : r_mv_addr - AW'(1);
                o_wdata  = i_rdata;
                n_mv_vld = 1'b0;
                if (r_up) begin
                    n_state = S_PUT;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                o_we    = 1'b1;
                o_waddr = r_stop;
                o_wdata = r_val;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                n_rd    = i_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_raddr   = r_idx;
    assign o_req_rdy = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_DONE);

    always_comb begin
        o_res.status         = r_st;
        o_res.read_value     = 32'(r_rd);
        o_res.found_position = 5'(r_fp);
        o_res.element_count  = 5'(r_count);
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_mv_vld)
        else $error("flush without a pending move");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_vld && i_op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_IDLE && i_req_vld && i_op == OP_CLEAR) |=>
        (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1) ||
         r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");
`endif

endmodule

FILE: verif/tb_sequential_list_engine.sv
// Testbench for sequential_list_engine: directed table, then grow/shrink episodes of random
// list requests checked against a behavioral list model kept in the bench.
// Depends on rtl/sle_pkg.sv and rtl/sequential_list_engine.sv.
module tb_sequential_list_engine;
    import sle_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int N_RANDOM = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 40;
    localparam int HOLD_CYCLES = 120;
    localparam logic [3:0] OP_UNUSED_LO = 4'd11;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam t_result NO_RES = '0;
    localparam logic [31:0] EDGE_VALS [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                              32'h0000_0001, 32'h8000_0000};

    typedef struct {
        logic [3:0]  kind;
        logic [4:0]  pos;
        logic [31:0] val;
        logic [31:0] nval;
        bit          typed;
        t_result     exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;  // position[4:0], value[36:5], new_value[68:37]
    logic [3:0]  i_s_tuser;  // req_type[3:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;  // status[1:0], read_value[33:2],
                             // found_position[38:34], element_count[43:39]

    logic [31:0] list_mem [LIST_DEPTH];
    int          list_len;
    t_result     pending_outcomes [$];
    int          mismatch_cnt;
    int          cycle_cnt;
    bit          tx_gap_en;
    bit          rx_stall_en;
    bit          rx_hold_req;
    t_row        plan [26];

    sequential_list_engine #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (32)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_result make_result(input t_status st, input int fp, input int cnt);
        t_result r;
        r = '0;
        r.status = st;
        r.found_position = fp[4:0];
        r.element_count = cnt[4:0];
        return r;
    endfunction

    function automatic void drop_entry(input int p);
        int i;
        for (i = p; i < list_len; i++) list_mem[i - 1] = list_mem[i];
        list_len--;
    endfunction

    function automatic t_result list_outcome(input logic [3:0] kind, input logic [4:0] pos,
                                             input logic [31:0] val, input logic [31:0] nval);
        t_result r;
        int p;
        int hit;
        int i;
        r = '0;
        r.status = ST_OK;
        p = int'(pos);
        hit = 0;
        for (i = 1; i <= list_len; i++) begin
            if (list_mem[i - 1] == val) hit = i;
        end
        case (kind)
            OP_INSERT_AT: begin
                if (p < 1 || p > list_len + 1) begin
                    r.status = ST_BOUNDS;
                end else if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i - 1];
                    list_mem[p - 1] = val;
                    list_len++;
                    r.found_position = p[4:0];
                end
            end
            OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                    r.found_position = list_len[4:0];
                end
            end
            OP_READ_AT, OP_UPDATE_AT, OP_REMOVE_AT: begin
                if (p < 1 || p > list_len) begin
                    r.status = ST_BOUNDS;
                end else begin
                    r.found_position = p[4:0];
                    if (kind == OP_READ_AT) r.read_value = list_mem[p - 1];
                    else if (kind == OP_UPDATE_AT) list_mem[p - 1] = nval;
                    else drop_entry(p);
                end
            end
            OP_FIND, OP_UPDATE_MATCH, OP_REMOVE_MATCH, OP_PRIOR, OP_NEXT: begin
                if (hit == 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.found_position = hit[4:0];
                    case (kind)
                        OP_UPDATE_MATCH: list_mem[hit - 1] = nval;
                        OP_REMOVE_MATCH: drop_entry(hit);
                        OP_PRIOR: begin
                            if (hit == 1) r.status = ST_NOTFOUND;
                            else r.read_value = list_mem[hit - 2];
                        end
                        OP_NEXT: begin
                            if (hit >= list_len) r.status = ST_NOTFOUND;
                            else r.read_value = list_mem[hit];
                        end
                        default: ;
                    endcase
                end
            end
            OP_CLEAR: list_len = 0;
            default: ;
        endcase
        r.element_count = list_len[4:0];
        return r;
    endfunction

    task automatic send_request(input logic [3:0] kind, input logic [4:0] pos,
                                input logic [31:0] val, input logic [31:0] nval,
                                input bit typed, input t_result typed_res);
        t_result predicted;
        int gap;
        if (tx_gap_en && $urandom_range(0, 99) < 30) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {3'b000, nval, val, pos};
        i_s_tuser <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = list_outcome(kind, pos, val, nval);
        pending_outcomes.push_back(typed ? typed_res : predicted);
    endtask

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int k;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
            end else begin
                i_m_tready <= rx_stall_en ? ($urandom_range(0, 99) >= 30) : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[43:0];
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result transaction: %h", o_m_tdata);
                mismatch_cnt++;
            end else begin
                want = pending_outcomes.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatch_cnt++;
                end
                if (got.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                    mismatch_cnt++;
                end
                if (got.found_position !== want.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, got.found_position);
                    mismatch_cnt++;
                end
                if (got.element_count !== want.element_count) begin
                    $error("element_count: expected %0d, got %0d",
                           want.element_count, got.element_count);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int i;
        int n;
        int w;
        int full_tries;
        int shrink_floor;
        bit growing;
        logic [3:0] kind;
        logic [4:0] pos;
        logic [31:0] val;
        logic [31:0] nval;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        list_len = 0;
        tx_gap_en = 1'b1;
        rx_stall_en = 1'b1;
        rx_hold_req = 1'b0;
        plan = '{
            '{OP_READ_AT,      5'd0,  32'h0,         32'h0, 1'b1, make_result(ST_BOUNDS, 0, 0)},
            '{OP_FIND,         5'd0,  32'h0,         32'h0, 1'b1, make_result(ST_NOTFOUND, 0, 0)},
            '{OP_NEXT,         5'd0,  32'h0,         32'h0, 1'b1, make_result(ST_NOTFOUND, 0, 0)},
            '{OP_INSERT_AT,    5'd0,  32'h1,         32'h0, 1'b1, make_result(ST_BOUNDS, 0, 0)},
            '{OP_INSERT_AT,    5'd2,  32'h1,         32'h0, 1'b1, make_result(ST_BOUNDS, 0, 0)},
            '{OP_INSERT_AT,    5'd1,  32'h0,         32'h0, 1'b1, make_result(ST_OK, 1, 1)},
            '{OP_APPEND,       5'd0,  32'hFFFF_FFFF, 32'h0, 1'b1, make_result(ST_OK, 2, 2)},
            '{OP_INSERT_AT,    5'd3,  32'h8000_0001, 32'h0, 1'b0, NO_RES},
            '{OP_INSERT_AT,    5'd1,  32'h5A5A_A5A5, 32'h0, 1'b0, NO_RES},
            '{OP_INSERT_AT,    5'd2,  32'hFFFF_FFFF, 32'h0, 1'b0, NO_RES},
            '{OP_READ_AT,      5'd31, 32'h0,         32'h0, 1'b1, make_result(ST_BOUNDS, 0, 5)},
            '{OP_READ_AT,      5'd6,  32'h0,         32'h0, 1'b1, make_result(ST_BOUNDS, 0, 5)},
            '{OP_READ_AT,      5'd5,  32'h0,         32'h0, 1'b0, NO_RES},
            '{OP_FIND,         5'd0,  32'hFFFF_FFFF, 32'h0, 1'b0, NO_RES},
            '{OP_PRIOR,        5'd0,  32'hFFFF_FFFF, 32'h0, 1'b0, NO_RES},
            '{OP_NEXT,         5'd0,  32'h8000_0001, 32'h0, 1'b0, NO_RES},
            '{OP_PRIOR,        5'd0,  32'h5A5A_A5A5, 32'h0, 1'b0, NO_RES},
            '{OP_UPDATE_AT,    5'd2,  32'h0, 32'h1234_5678, 1'b0, NO_RES},
            '{OP_UPDATE_AT,    5'd0,  32'h0, 32'h1234_5678, 1'b1, make_result(ST_BOUNDS, 0, 5)},
            '{OP_UPDATE_MATCH, 5'd0,  32'h8000_0001, 32'hFFFF_FFFF, 1'b0, NO_RES},
            '{OP_REMOVE_MATCH, 5'd0,  32'h1234_5678, 32'h0, 1'b0, NO_RES},
            '{OP_REMOVE_AT,    5'd1,  32'h0,         32'h0, 1'b0, NO_RES},
            '{OP_REMOVE_AT,    5'd9,  32'h0,         32'h0, 1'b1, make_result(ST_BOUNDS, 0, 3)},
            '{OP_UNUSED_HI,    5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_RES},
            '{OP_CLEAR,        5'd0,  32'h0,         32'h0, 1'b1, make_result(ST_OK, 0, 0)},
            '{OP_REMOVE_MATCH, 5'd0,  32'h0,         32'h0, 1'b1, make_result(ST_NOTFOUND, 0, 0)}
        };
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < $size(plan); i++) begin
            send_request(plan[i].kind, plan[i].pos, plan[i].val, plan[i].nval,
                         plan[i].typed, plan[i].exp);
        end

        // alternate filling the list past full and draining it down to a random floor of 0 to 3
        growing = 1'b1;
        full_tries = 0;
        shrink_floor = 0;
        for (n = 0; n < N_RANDOM; n++) begin
            if (n == 120) begin
                tx_gap_en = 1'b0;
                rx_stall_en = 1'b0;
            end
            if (n == 220) begin
                tx_gap_en = 1'b1;
                rx_stall_en = 1'b1;
            end
            if (n == 300) begin
                tx_gap_en = 1'b0;
                rx_hold_req = 1'b1;
            end
            if (n == 330) tx_gap_en = 1'b1;

            if (growing) begin
                if (list_len == LIST_DEPTH) full_tries++;
                if (full_tries > 3) begin
                    growing = 1'b0;
                    full_tries = 0;
                    shrink_floor = $urandom_range(0, 3);
                end
            end else if (list_len <= shrink_floor) begin
                growing = 1'b1;
            end

            w = $urandom_range(0, 99);
            if (w < 3 && !growing) kind = OP_CLEAR;
            else if (w < 6) kind = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else if (w < 55 && growing) kind = 4'($urandom_range(OP_INSERT_AT, OP_APPEND));
            else if (w < 50) kind = $urandom_range(0, 1) ? OP_REMOVE_AT : OP_REMOVE_MATCH;
            else kind = 4'($urandom_range(OP_INSERT_AT, OP_NEXT));

            w = $urandom_range(0, 99);
            if (w < 80) pos = 5'($urandom_range(1, list_len + 1));
            else if (w < 90) pos = '0;
            else pos = 5'($urandom_range(0, 31));

            w = $urandom_range(0, 99);
            if (list_len > 0 && w < 50) val = list_mem[$urandom_range(0, list_len - 1)];
            else if (w < 75) val = EDGE_VALS[$urandom_range(0, 3)];
            else val = $urandom;
            nval = $urandom_range(0, 1) ? $urandom : EDGE_VALS[$urandom_range(0, 3)];

            send_request(kind, pos, val, nval, 1'b0, NO_RES);
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
